// ===== design/size_class_chunk_allocator_core_assert.svh =====
// Assertion macros shared by the allocator checker.
`ifndef SIZE_CLASS_CHUNK_ALLOCATOR_CORE_ASSERT_SVH
`define SIZE_CLASS_CHUNK_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCCA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/scca_pkg.sv =====
// Shared types and constants of the size-class chunk allocator.
`timescale 1ns / 1ps

package scca_pkg;

    localparam int DEF_PAGE_BYTES      = 4096;
    localparam int DEF_NUM_CLASSES     = 7;
    localparam int DEF_MIN_CHUNK_BYTES = 16;

    // fixed port field widths
    localparam int SIZE_W   = 12;
    localparam int CLASS_W  = 3;
    localparam int OFFSET_W = 12;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_BAD_FREE  = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } link_req_t;

    typedef struct packed {
        logic init_busy;
    } link_stat_t;

endpackage

// ===== design/scca_links.sv =====
// Next-link memory with its post-reset initialization sweep.
`timescale 1ns / 1ps

module scca_links #(
    parameter int NUM_CLASSES     = scca_pkg::DEF_NUM_CLASSES,
    parameter int PAGE_BYTES      = scca_pkg::DEF_PAGE_BYTES,
    parameter int MIN_CHUNK_BYTES = scca_pkg::DEF_MIN_CHUNK_BYTES,
    localparam int SLOTS      = PAGE_BYTES / MIN_CHUNK_BYTES,
    localparam int SLOT_W     = $clog2(SLOTS),
    localparam int MIN_SH     = $clog2(MIN_CHUNK_BYTES),
    localparam int OFF_W      = $clog2(PAGE_BYTES),
    localparam int CLS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1,
    localparam int LINK_DEPTH = NUM_CLASSES * SLOTS,
    localparam int LA_W       = $clog2(LINK_DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  scca_pkg::link_req_t   req,
    input  logic [LA_W-1:0]       rd_addr,
    input  logic [LA_W-1:0]       wr_addr,
    input  logic [OFF_W-1:0]      wr_data,
    output logic [OFF_W-1:0]      rd_data,
    output scca_pkg::link_stat_t  stat
);
    import scca_pkg::*;

    logic [OFF_W-1:0]  mem [LINK_DEPTH];
    logic [OFF_W-1:0]  rd_data_reg;

    logic              busy_reg;
    logic [CLS_W-1:0]  cls_cnt_reg;
    logic [SLOT_W-1:0] slot_cnt_reg;

    logic [31:0]       init_off;
    logic [31:0]       init_sz;
    logic              init_has;
    logic              init_chain;
    logic [OFF_W-1:0]  init_data;
    logic              init_last;
    logic              slot_last;

    logic              we;
    logic [LA_W-1:0]   waddr;
    logic [OFF_W-1:0]  wdata;

    // reset value of the entry under the sweep: ascending chain per class
    always_comb
    begin
        init_off   = 32'(slot_cnt_reg) << MIN_SH;
        init_sz    = 32'(MIN_CHUNK_BYTES) << cls_cnt_reg;
        init_has   = (init_sz << 1) <= 32'(PAGE_BYTES);
        init_chain = (init_off != 32'd0) && ((init_off & (init_sz - 32'd1)) == 32'd0)
                     && ((init_off + init_sz) < 32'(PAGE_BYTES));
        init_data  = (init_has && init_chain) ? OFF_W'(init_off + init_sz) : '0;
        slot_last  = slot_cnt_reg == SLOT_W'(SLOTS - 1);
        init_last  = slot_last && (cls_cnt_reg == CLS_W'(NUM_CLASSES - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            cls_cnt_reg  <= '0;
            slot_cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            slot_cnt_reg <= slot_cnt_reg + 1'b1;
            if (init_last)
            begin
                busy_reg <= 1'b0;
            end
            else if (slot_last)
            begin
                cls_cnt_reg <= cls_cnt_reg + 1'b1;
            end
        end
    end

    assign we    = busy_reg || req.wr_en;
    assign waddr = busy_reg ? LA_W'({cls_cnt_reg, slot_cnt_reg}) : wr_addr;
    assign wdata = busy_reg ? init_data : wr_data;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data        = rd_data_reg;
    assign stat.init_busy = busy_reg;

endmodule

// ===== design/size_class_chunk_allocator_core.sv =====
// Top level of the size-class chunk allocator.
`timescale 1ns / 1ps

// Segregated free-list allocator, one page per power-of-two chunk class.
// Input channel (in_valid / in_stall): one item is an allocate (kind 0,
// alloc_size) or a free (kind 1, free_class, free_offset).
// Output channel (out_valid / out_stall): exactly one result item per
// input item, in order: status, granted_class, granted_offset.
// On accept (S_IDLE) the item looks up the class head and, for an
// allocate, reads the link memory at that head; in S_EXEC, once the output
// register is free, it writes the new head (and, for a free, the pushed
// link) and loads the output register. in_stall is high in the cycle after
// every accepted item.
// The output register decouples the channels: while a result waits under
// out_stall, one more item can be accepted and held; it completes as soon
// as the output register frees up. Then in_stall stays high.
// After reset the link memory is swept once to build the per-class
// ascending free chains, with in_stall held high. Heads reset at once.
// PAGE_BYTES and MIN_CHUNK_BYTES are expected to be powers of two.
module size_class_chunk_allocator_core #(
    parameter int NUM_CLASSES     = scca_pkg::DEF_NUM_CLASSES,
    parameter int PAGE_BYTES      = scca_pkg::DEF_PAGE_BYTES,
    parameter int MIN_CHUNK_BYTES = scca_pkg::DEF_MIN_CHUNK_BYTES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic [scca_pkg::SIZE_W-1:0]     alloc_size,
    input  logic [scca_pkg::CLASS_W-1:0]    free_class,
    input  logic [scca_pkg::OFFSET_W-1:0]   free_offset,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic [scca_pkg::CLASS_W-1:0]    granted_class,
    output logic [scca_pkg::OFFSET_W-1:0]   granted_offset
);
    import scca_pkg::*;

    localparam int SLOTS      = PAGE_BYTES / MIN_CHUNK_BYTES;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int MIN_SH     = $clog2(MIN_CHUNK_BYTES);
    localparam int OFF_W      = $clog2(PAGE_BYTES);
    localparam int CLS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int LINK_DEPTH = NUM_CLASSES * SLOTS;
    localparam int LA_W       = $clog2(LINK_DEPTH);
    localparam int MAX_REQ    = MIN_CHUNK_BYTES << (NUM_CLASSES - 1);

    // head reset value: first chunk, or empty if a chunk exceeds half a page
    function automatic logic [OFF_W-1:0] head_init(input int c);
        int sz;
        sz = MIN_CHUNK_BYTES << c;
        return (2 * sz <= PAGE_BYTES) ? OFF_W'(sz) : '0;
    endfunction

    // FSM
    state_t            state_reg;
    state_t            state_next;
    logic              in_take;
    logic              out_free;
    logic              exec_fire;

    // class heads
    logic [OFF_W-1:0]  heads_reg [NUM_CLASSES];

    // accept-side decode
    logic [31:0]       size32;
    logic [31:0]       foff32;
    logic [31:0]       fmask;
    logic              too_large;
    logic              free_bad;
    logic [CLS_W-1:0]  acls;
    logic [CLS_W-1:0]  sel_cls;
    logic [OFF_W-1:0]  head_sel;
    logic [SLOT_W-1:0] slot_sel;
    logic [LA_W-1:0]   addr_sel;
    status_t           p_status;
    logic              p_upd;
    logic              p_rd;

    // item in flight
    status_t           pend_status_reg;
    logic              pend_free_reg;
    logic              pend_upd_reg;
    logic [CLS_W-1:0]  pend_cls_reg;
    logic [OFF_W-1:0]  pend_off_reg;
    logic [OFF_W-1:0]  pend_head_reg;
    logic [LA_W-1:0]   pend_addr_reg;

    // output register
    logic              out_valid_reg;
    status_t           status_reg;
    logic [CLASS_W-1:0]  gcls_reg;
    logic [OFFSET_W-1:0] goff_reg;

    // link memory
    link_req_t         link_req;
    link_stat_t        link_stat;
    logic [OFF_W-1:0]  link_rdata;

    scca_links #(
        .NUM_CLASSES     (NUM_CLASSES),
        .PAGE_BYTES      (PAGE_BYTES),
        .MIN_CHUNK_BYTES (MIN_CHUNK_BYTES)
    ) u_links (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (link_req),
        .rd_addr (addr_sel),
        .wr_addr (pend_addr_reg),
        .wr_data (pend_head_reg),
        .rd_data (link_rdata),
        .stat    (link_stat)
    );

    // ---------------------------------------------------------------
    // Handshake and sequencing
    // ---------------------------------------------------------------
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        in_take    = 1'b0;
        exec_fire  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = link_stat.init_busy;
                in_take  = in_valid && !link_stat.init_busy;
                if (in_take)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold here while the previous result still sits stalled
                exec_fire = out_free;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Accept-side decode: class choice, checks, head lookup, link read
    // ---------------------------------------------------------------
    always_comb
    begin
        size32    = 32'(alloc_size);
        foff32    = 32'(free_offset);
        too_large = size32 > 32'(MAX_REQ);

        // smallest class whose chunk holds the request, capped at the top
        acls = CLS_W'(NUM_CLASSES - 1);
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if (size32 <= (32'(MIN_CHUNK_BYTES) << c))
            begin
                acls = CLS_W'(c);
            end
        end

        fmask    = (32'(MIN_CHUNK_BYTES) << free_class) - 32'd1;
        free_bad = (32'(free_class) >= 32'(NUM_CLASSES)) || (foff32 == 32'd0)
                   || (foff32 >= 32'(PAGE_BYTES)) || ((foff32 & fmask) != 32'd0);

        // a bad free never indexes the heads with its class
        sel_cls  = (kind == KIND_FREE && !free_bad) ? CLS_W'(free_class) : acls;
        head_sel = heads_reg[sel_cls];
        slot_sel = (kind == KIND_FREE) ? SLOT_W'(foff32 >> MIN_SH)
                                       : SLOT_W'(32'(head_sel) >> MIN_SH);
        addr_sel = LA_W'({sel_cls, slot_sel});

        p_status = ST_OK;
        p_upd    = 1'b0;
        p_rd     = 1'b0;
        if (kind == KIND_ALLOC)
        begin
            if (too_large)
            begin
                p_status = ST_TOO_LARGE;
            end
            else if (head_sel == '0)
            begin
                p_status = ST_EMPTY;
            end
            else
            begin
                p_upd = 1'b1;
                p_rd  = 1'b1;
            end
        end
        else
        begin
            if (free_bad)
            begin
                p_status = ST_BAD_FREE;
            end
            else
            begin
                p_upd = 1'b1;
            end
        end
    end

    assign link_req.rd_en = in_take && p_rd;
    assign link_req.wr_en = exec_fire && pend_upd_reg && pend_free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_upd_reg  <= 1'b0;
            pend_free_reg <= 1'b0;
        end
        else if (in_take)
        begin
            pend_upd_reg  <= p_upd;
            pend_free_reg <= kind;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pend_status_reg <= p_status;
            pend_cls_reg    <= sel_cls;
            pend_off_reg    <= (kind == KIND_FREE) ? OFF_W'(foff32) : head_sel;
            pend_head_reg   <= head_sel;
            pend_addr_reg   <= addr_sel;
        end
    end

    // ---------------------------------------------------------------
    // Head update: pop takes the link read at accept, push takes the
    // freed offset (its link is written with the old head alongside)
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                heads_reg[c] <= head_init(c);
            end
        end
        else if (exec_fire && pend_upd_reg)
        begin
            heads_reg[pend_cls_reg] <= pend_free_reg ? pend_off_reg : link_rdata;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            status_reg <= pend_status_reg;
            // class is reported for allocates that found a class only
            gcls_reg   <= (pend_free_reg || pend_status_reg == ST_TOO_LARGE)
                          ? '0 : CLASS_W'(pend_cls_reg);
            goff_reg   <= (pend_upd_reg && !pend_free_reg) ? OFFSET_W'(pend_off_reg) : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign granted_class  = gcls_reg;
    assign granted_offset = goff_reg;

endmodule

// ===== design/scca_check.sv =====
// Port-level checker of the allocator, bound to the top level.
`timescale 1ns / 1ps
`include "size_class_chunk_allocator_core_assert.svh"

module scca_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    status,
    input logic [scca_pkg::CLASS_W-1:0]  granted_class,
    input logic [scca_pkg::OFFSET_W-1:0] granted_offset
);
    import scca_pkg::*;

    logic                                  in_take;
    logic                                  out_hold;
    logic                                  rejected;
    logic                                  no_chunk;
    logic                                  off_zero;
    logic                                  grant_zero;
    logic [2+CLASS_W+OFFSET_W-1:0]         out_word;

    assign in_take    = in_valid && !in_stall;
    assign out_hold   = out_valid && out_stall;
    assign rejected   = out_valid && (status == ST_TOO_LARGE);
    assign no_chunk   = out_valid && (status == ST_EMPTY || status == ST_BAD_FREE);
    assign off_zero   = granted_offset == '0;
    assign grant_zero = off_zero && (granted_class == '0);
    assign out_word   = {status, granted_class, granted_offset};

    `SCCA_ASSERT_NEXT(a_out_hold, out_hold, out_valid && $stable(out_word), "stalled result moved")
    `SCCA_ASSERT_NEXT(a_busy_after_take, in_take, in_stall, "item taken on back-to-back cycle")
    `SCCA_ASSERT_SAME(a_reject_zero, rejected, grant_zero, "too-large result not zeroed")
    `SCCA_ASSERT_SAME(a_fail_no_offset, no_chunk, off_zero, "failed item returned an offset")

endmodule

bind size_class_chunk_allocator_core scca_check u_scca_check (.*);
